### hw/rtl/uint128_alu_macros.svh
`ifndef UINT128_ALU_MACROS_SVH
`define UINT128_ALU_MACROS_SVH

// same-cycle implication
`define U128_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define U128_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/u128alu_pkg.sv
`default_nettype none

package u128alu_pkg;

	typedef enum logic [3:0] {
		OP_ADD     = 4'd0,
		OP_SUB     = 4'd1,
		OP_AND     = 4'd2,
		OP_OR      = 4'd3,
		OP_XOR     = 4'd4,
		OP_NOT     = 4'd5,
		OP_SHIFT   = 4'd6,
		OP_ROTATE  = 4'd7,
		OP_MUL     = 4'd8,
		OP_CMP     = 4'd9,
		OP_INC     = 4'd10,
		OP_DEC     = 4'd11,
		OP_BITTEST = 4'd12,
		OP_BITLEN  = 4'd13
	} op_t;

	localparam logic [1:0] CMP_EQ = 2'b00;
	localparam logic [1:0] CMP_GT = 2'b01;
	localparam logic [1:0] CMP_LT = 2'b11;

	localparam int unsigned CHUNK_W = 16;
	localparam int unsigned N_CHUNK = 128 / CHUNK_W;

	typedef struct packed {
		op_t          op;
		logic [127:0] a;
		logic [127:0] b;
		logic [8:0]   shift_amount;
		logic [6:0]   bit_index;
	} operand_t;

	// position of the highest set bit of a 16-bit chunk
	function automatic logic [3:0] hi_pos16(input logic [CHUNK_W-1:0] v);
		logic [3:0] pos;
		pos = '0;
		for (int i = 0; i < CHUNK_W; i++) begin
			if (v[i]) begin
				pos = 4'(i);
			end
		end
		return pos;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/uint128_alu.sv
// 128-bit unsigned ALU: add, sub, and, or, xor, not, shift, rotate, low-half multiply,
// compare, increment, decrement, bit test and bit length. A transaction on the operand
// channel gives one transaction on the result channel, in order. One transaction is
// accepted every cycle while the result side does not stall: the pipeline has an input
// register, a stage that forms the 32x32 partial products of the multiply, and a result
// register where the partial products are summed. operand_stall comes from a one-entry
// skid register, so it never depends combinationally on result_stall. Fields that an
// operation does not produce read as zero; opcodes 14 and 15 give an all-zero result.
`default_nettype none

`include "uint128_alu_macros.svh"

module uint128_alu (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              operand_valid,
	output logic                   operand_stall,
	input  wire logic [3:0]        op,
	input  wire logic [63:0]       a_low,
	input  wire logic [63:0]       a_high,
	input  wire logic [63:0]       b_low,
	input  wire logic [63:0]       b_high,
	input  wire logic signed [8:0] shift_amount,
	input  wire logic [6:0]        bit_index,
	output logic                   result_valid,
	input  wire logic              result_stall,
	output logic [63:0]            result_low,
	output logic [63:0]            result_high,
	output logic signed [1:0]      compare_result,
	output logic                   bit_value,
	output logic [7:0]             bit_length
);

	u128alu_pkg::operand_t in_w;
	u128alu_pkg::operand_t skid_q;
	u128alu_pkg::operand_t opnd_s1;
	logic                  skid_full_q;
	logic                  v_s1;
	logic                  v_s2;
	logic                  v_s3;
	logic                  rdy1;
	logic                  rdy2;
	logic                  rdy3;
	logic                  in_take;

	assign in_w = '{op: u128alu_pkg::op_t'(op), a: {a_high, a_low}, b: {b_high, b_low},
		shift_amount: shift_amount, bit_index: bit_index};

	assign rdy3          = !v_s3 || !result_stall;
	assign rdy2          = !v_s2 || rdy3;
	assign rdy1          = !v_s1 || rdy2;
	assign operand_stall = skid_full_q;
	assign in_take       = operand_valid && !operand_stall;

	// pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_full_q <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
		end else begin
			if (rdy1) begin
				skid_full_q <= 1'b0;
				v_s1        <= skid_full_q || in_take;
			end else if (in_take) begin
				skid_full_q <= 1'b1;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!rdy1 && in_take) begin
			skid_q <= in_w;
		end
		if (rdy1) begin
			opnd_s1 <= skid_full_q ? skid_q : in_w;
		end
	end

	// stage 2: arithmetic and logic ops, shifts, rotate, compare, bit test, partial products, chunk bit positions
	logic [127:0] a1;
	logic [127:0] b1;
	logic [8:0]   sh_raw;
	logic [8:0]   sh_mag;
	logic         sh_big;
	logic [255:0] rot_w;
	logic [127:0] val_w;
	logic [1:0]   cmp_w;
	logic         bit_w;

	assign a1     = opnd_s1.a;
	assign b1     = opnd_s1.b;
	assign sh_raw = opnd_s1.shift_amount;
	assign sh_mag = sh_raw[8] ? (~sh_raw + 9'd1) : sh_raw;
	assign sh_big = sh_mag[8] || sh_mag[7];
	assign rot_w  = {a1, a1} << sh_raw[6:0];

	always_comb begin
		val_w = '0;
		cmp_w = u128alu_pkg::CMP_EQ;
		bit_w = 1'b0;
		unique case (opnd_s1.op)
			u128alu_pkg::OP_ADD: begin
				val_w = a1 + b1;
			end
			u128alu_pkg::OP_SUB: begin
				val_w = a1 - b1;
			end
			u128alu_pkg::OP_AND: begin
				val_w = a1 & b1;
			end
			u128alu_pkg::OP_OR: begin
				val_w = a1 | b1;
			end
			u128alu_pkg::OP_XOR: begin
				val_w = a1 ^ b1;
			end
			u128alu_pkg::OP_NOT: begin
				val_w = ~a1;
			end
			u128alu_pkg::OP_SHIFT: begin
				if (sh_big) begin
					val_w = '0;
				end else if (sh_raw[8]) begin
					val_w = a1 >> sh_mag[6:0];
				end else begin
					val_w = a1 << sh_mag[6:0];
				end
			end
			u128alu_pkg::OP_ROTATE: begin
				val_w = rot_w[255:128];
			end
			u128alu_pkg::OP_CMP: begin
				if (a1 > b1) begin
					cmp_w = u128alu_pkg::CMP_GT;
				end else if (a1 < b1) begin
					cmp_w = u128alu_pkg::CMP_LT;
				end else begin
					cmp_w = u128alu_pkg::CMP_EQ;
				end
			end
			u128alu_pkg::OP_INC: begin
				val_w = a1 + 128'd1;
			end
			u128alu_pkg::OP_DEC: begin
				val_w = a1 - 128'd1;
			end
			u128alu_pkg::OP_BITTEST: begin
				bit_w = a1[opnd_s1.bit_index];
			end
			default: begin
				val_w = '0;
			end
		endcase
	end

	logic [63:0] p00_w;
	logic [63:0] p01_w;
	logic [63:0] p10_w;
	logic [63:0] p11_w;
	logic [63:0] q00_w;
	logic [63:0] q01_w;
	logic [63:0] q10_w;
	logic [63:0] r00_w;
	logic [63:0] r01_w;
	logic [63:0] r10_w;

	assign p00_w = 64'(a1[31:0])  * 64'(b1[31:0]);
	assign p01_w = 64'(a1[31:0])  * 64'(b1[63:32]);
	assign p10_w = 64'(a1[63:32]) * 64'(b1[31:0]);
	assign p11_w = 64'(a1[63:32]) * 64'(b1[63:32]);
	assign q00_w = 64'(a1[31:0])  * 64'(b1[95:64]);
	assign q01_w = 64'(a1[31:0])  * 64'(b1[127:96]);
	assign q10_w = 64'(a1[63:32]) * 64'(b1[95:64]);
	assign r00_w = 64'(a1[95:64]) * 64'(b1[31:0]);
	assign r01_w = 64'(a1[95:64]) * 64'(b1[63:32]);
	assign r10_w = 64'(a1[127:96]) * 64'(b1[31:0]);

	u128alu_pkg::op_t op_s2;
	logic [127:0]     val_s2;
	logic [1:0]       cmp_s2;
	logic             bit_s2;
	logic [63:0]      p00_s2;
	logic [63:0]      p01_s2;
	logic [63:0]      p10_s2;
	logic [63:0]      p11_s2;
	logic [63:0]      q00_s2;
	logic [31:0]      q01_s2;
	logic [31:0]      q10_s2;
	logic [63:0]      r00_s2;
	logic [31:0]      r01_s2;
	logic [31:0]      r10_s2;
	logic [u128alu_pkg::N_CHUNK-1:0] nz_s2;
	logic [3:0]       pos_s2 [u128alu_pkg::N_CHUNK];

	always_ff @(posedge clk) begin
		if (rdy2) begin
			op_s2  <= opnd_s1.op;
			val_s2 <= val_w;
			cmp_s2 <= cmp_w;
			bit_s2 <= bit_w;
			p00_s2 <= p00_w;
			p01_s2 <= p01_w;
			p10_s2 <= p10_w;
			p11_s2 <= p11_w;
			q00_s2 <= q00_w;
			q01_s2 <= q01_w[31:0];
			q10_s2 <= q10_w[31:0];
			r00_s2 <= r00_w;
			r01_s2 <= r01_w[31:0];
			r10_s2 <= r10_w[31:0];
			for (int i = 0; i < u128alu_pkg::N_CHUNK; i++) begin
				nz_s2[i]  <= |a1[i*u128alu_pkg::CHUNK_W +: u128alu_pkg::CHUNK_W];
				pos_s2[i] <= u128alu_pkg::hi_pos16(
					a1[i*u128alu_pkg::CHUNK_W +: u128alu_pkg::CHUNK_W]);
			end
		end
	end

	// stage 3: product sum, bit length, result register
	logic [127:0] mul_w;
	logic [7:0]   blen_w;

	assign mul_w = {64'd0, p00_s2} + {32'd0, p01_s2, 32'd0} + {32'd0, p10_s2, 32'd0}
		+ {p11_s2, 64'd0} + {q00_s2, 64'd0} + {r00_s2, 64'd0}
		+ {q01_s2, 96'd0} + {q10_s2, 96'd0} + {r01_s2, 96'd0} + {r10_s2, 96'd0};

	always_comb begin
		blen_w = '0;
		for (int i = 0; i < u128alu_pkg::N_CHUNK; i++) begin
			if (nz_s2[i]) begin
				blen_w = {1'b0, 3'(i), pos_s2[i]} + 8'd1;
			end
		end
	end

	logic [127:0] val_s3;
	logic [1:0]   cmp_s3;
	logic         bit_s3;
	logic [7:0]   blen_s3;

	always_ff @(posedge clk) begin
		if (rdy3) begin
			val_s3  <= (op_s2 == u128alu_pkg::OP_MUL) ? mul_w : val_s2;
			cmp_s3  <= cmp_s2;
			bit_s3  <= bit_s2;
			blen_s3 <= (op_s2 == u128alu_pkg::OP_BITLEN) ? blen_w : 8'd0;
		end
	end

	assign result_valid   = v_s3;
	assign result_low     = val_s3[63:0];
	assign result_high    = val_s3[127:64];
	assign compare_result = cmp_s3;
	assign bit_value      = bit_s3;
	assign bit_length     = blen_s3;

	`U128_ASSERT_NOW(a_skid_needs_s1, skid_full_q, v_s1, "skid holds data while s1 is empty")
	`U128_ASSERT_NEXT(a_skid_fill, in_take && !rdy1, skid_full_q, "blocked transaction lost")
	`U128_ASSERT_NOW(a_blen_range, v_s3, blen_s3 <= 8'd128, "bit length above 128")
	`U128_ASSERT_NOW(a_cmp_code, v_s3, cmp_s3 != 2'b10, "invalid compare code")

endmodule

`default_nettype wire
